@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// each use expands to one labeled concurrent assertion on aclk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked at every edge out of reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// non-overlapping implication, consequent checked in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/nmscf_pkg.sv @@
// ----------------------------------------------------------------------------
// nmscf_pkg: shared types and constants for the sentence checksum framer
// Character codes, sentence tag tables, result layout and hex helper.
// ----------------------------------------------------------------------------
`default_nettype none

package nmscf_pkg;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // sentence kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_HDT   = 2'd2;

    // tag length and hex base
    localparam logic [7:0] KIND_LEN = 8'd5;
    localparam int         HEX_BASE = 16;

    // saturation limits and needed hex digit count
    localparam logic [1:0] CNT_SAT   = 2'd3;
    localparam logic [1:0] HEX_NEED  = 2'd2;
    localparam logic [7:0] LEN_SAT   = 8'd255;

    // stream widths
    localparam int IN_WIDTH  = 8;
    localparam int OUT_WIDTH = 24;

    // result bit positions inside m_tdata
    localparam int OK_BIT   = 0;
    localparam int KIND_LO  = 1;
    localparam int CSUM_LO  = 3;
    localparam int LEN_LO   = 11;
    localparam int PAD_LO   = 19;

    typedef struct packed {
        logic       checksum_ok;
        logic [1:0] sentence_kind;
        logic [7:0] computed_checksum;
        logic [7:0] body_length;
    } result_t;

    // tag characters of "GNRMC" by position
    function automatic logic [7:0] rmc_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h47; // G
            3'd1: ch = 8'h4E; // N
            3'd2: ch = 8'h52; // R
            3'd3: ch = 8'h4D; // M
            3'd4: ch = 8'h43; // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // tag characters of "GPHDT" by position
    function automatic logic [7:0] hdt_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h47; // G
            3'd1: ch = 8'h50; // P
            3'd2: ch = 8'h48; // H
            3'd3: ch = 8'h44; // D
            3'd4: ch = 8'h54; // T
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // uppercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] ch;
        if (v < 4'd10) begin
            ch = 8'h30 + {4'd0, v};
        end else begin
            ch = 8'h41 + {4'd0, v} - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ sv/nmscf_parser.sv @@
// ----------------------------------------------------------------------------
// nmscf_parser: sentence state and checksum logic
// Holds the per-sentence state, updates it for one character per step and
// flags the step that closes a sentence together with its result.
// ----------------------------------------------------------------------------
`default_nettype none

module nmscf_parser
    import nmscf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] rx_byte,
    output logic            emit,
    output result_t         result
);

    logic       in_sentence_reg,  in_sentence_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic [1:0] star_count_reg,   star_count_next;
    logic [7:0] hex_hi_reg,       hex_hi_next;
    logic [7:0] hex_lo_reg,       hex_lo_next;
    logic [1:0] hex_count_reg,    hex_count_next;
    logic [7:0] length_count_reg, length_count_next;
    logic [1:0] kind_match_reg,   kind_match_next;

    logic is_dollar;
    logic is_eol;
    logic is_star;

    assign is_dollar = (rx_byte == CH_DOLLAR);
    assign is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_star   = (rx_byte == CH_STAR);

    // result of the sentence held in the state
    always_comb begin
        result.checksum_ok = (star_count_reg == 2'd1) && (hex_count_reg == HEX_NEED) &&
                             (hex_hi_reg == hex_digit(running_xor_reg[7:4])) &&
                             (hex_lo_reg == hex_digit(running_xor_reg[3:0]));
        result.sentence_kind = KIND_OTHER;
        if (length_count_reg >= KIND_LEN) begin
            if (kind_match_reg[0]) begin
                result.sentence_kind = KIND_RMC;
            end else if (kind_match_reg[1]) begin
                result.sentence_kind = KIND_HDT;
            end
        end
        result.computed_checksum = running_xor_reg;
        result.body_length       = length_count_reg;
    end

    // next state for one character
    always_comb begin
        in_sentence_next  = in_sentence_reg;
        running_xor_next  = running_xor_reg;
        star_count_next   = star_count_reg;
        hex_hi_next       = hex_hi_reg;
        hex_lo_next       = hex_lo_reg;
        hex_count_next    = hex_count_reg;
        length_count_next = length_count_reg;
        kind_match_next   = kind_match_reg;
        emit              = 1'b0;

        if (step_en) begin
            if (!in_sentence_reg || is_dollar) begin
                // a dollar opens a sentence, closing any open one
                if (is_dollar) begin
                    emit              = in_sentence_reg;
                    in_sentence_next  = 1'b1;
                    running_xor_next  = 8'd0;
                    star_count_next   = 2'd0;
                    hex_hi_next       = 8'd0;
                    hex_lo_next       = 8'd0;
                    hex_count_next    = 2'd0;
                    length_count_next = 8'd0;
                    kind_match_next   = 2'b11;
                end
            end else if (is_eol) begin
                emit             = 1'b1;
                in_sentence_next = 1'b0;
            end else if (is_star) begin
                if (star_count_reg != CNT_SAT) begin
                    star_count_next = star_count_reg + 2'd1;
                end
            end else if (star_count_reg == 2'd0) begin
                // body character
                running_xor_next = running_xor_reg ^ rx_byte;
                if (length_count_reg < KIND_LEN) begin
                    if (rx_byte != rmc_char(length_count_reg[2:0])) begin
                        kind_match_next[0] = 1'b0;
                    end
                    if (rx_byte != hdt_char(length_count_reg[2:0])) begin
                        kind_match_next[1] = 1'b0;
                    end
                end
                if (length_count_reg != LEN_SAT) begin
                    length_count_next = length_count_reg + 8'd1;
                end
            end else begin
                // checksum character
                if (hex_count_reg == 2'd0) begin
                    hex_hi_next = rx_byte;
                end else if (hex_count_reg == 2'd1) begin
                    hex_lo_next = rx_byte;
                end
                if (hex_count_reg != CNT_SAT) begin
                    hex_count_next = hex_count_reg + 2'd1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg  <= 1'b0;
            running_xor_reg  <= 8'd0;
            star_count_reg   <= 2'd0;
            hex_hi_reg       <= 8'd0;
            hex_lo_reg       <= 8'd0;
            hex_count_reg    <= 2'd0;
            length_count_reg <= 8'd0;
            kind_match_reg   <= 2'b11;
        end else begin
            in_sentence_reg  <= in_sentence_next;
            running_xor_reg  <= running_xor_next;
            star_count_reg   <= star_count_next;
            hex_hi_reg       <= hex_hi_next;
            hex_lo_reg       <= hex_lo_next;
            hex_count_reg    <= hex_count_next;
            length_count_reg <= length_count_next;
            kind_match_reg   <= kind_match_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/nmscf_out_reg.sv @@
// ----------------------------------------------------------------------------
// nmscf_out_reg: result register of the framer
// Holds one result until the downstream side takes it and packs it into
// the output data word.
// ----------------------------------------------------------------------------
`default_nettype none

module nmscf_out_reg
    import nmscf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load_en,
    input  wire logic                 emit,
    input  wire result_t              result,
    output logic                      m_tvalid,
    output logic [OUT_WIDTH-1:0]      m_tdata
);

    logic    valid_reg, valid_next;
    result_t data_reg,  data_next;

    // load a new result or drop the taken one when the stage advances
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load_en) begin
            valid_next = emit;
            data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // pack fields from the lowest bit up, zero fill to whole bytes
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, data_reg.body_length, data_reg.computed_checksum,
                       data_reg.sentence_kind, data_reg.checksum_ok};

endmodule

`default_nettype wire

@@ sv/nmea_sentence_checksum_framer_core.sv @@
// Path: an accepted character passes the input and result registers to m_tvalid.
// Throughput: one character per cycle unless stalled; the parser state register is the
// only loop and it updates once per cycle.
// Stalls only while the result register is full and m_tready is low.
// Reset: synchronous active low aresetn clears the stage valid bits and
// the sentence state, so the block waits for the next dollar.
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer_core: NMEA sentence checksum framer
// Input register, sentence parser and result register in one pass; one
// result per closed sentence with checksum status, kind, xor and length.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checksum_framer_core
    import nmscf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input characters
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_WIDTH-1:0]  s_tdata,  // [7:0] rx_byte
    // sentence results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_WIDTH-1:0]      m_tdata   // [0] checksum_ok, [2:1] sentence_kind,
                                                // [10:3] computed_checksum,
                                                // [18:11] body_length, [23:19] zero
);

    logic                in_valid_reg, in_valid_next;
    logic [IN_WIDTH-1:0] in_byte_reg,  in_byte_next;
    logic                advance;
    logic                emit;
    result_t             result;

    // pipeline moves when the result register is free or being emptied
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    // sentence parser
    nmscf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_valid_reg && advance),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    // result register
    nmscf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (advance),
        .emit     (emit && in_valid_reg),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ sv/nmscf_checker.sv @@
// ----------------------------------------------------------------------------
// nmscf_checker: port-level checks of the sentence checksum framer
// Watches the top level ports and checks result encoding and hold rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nmscf_checker
    import nmscf_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_WIDTH-1:0] m_tdata
);

    logic [1:0] kind;
    logic [7:0] len;

    assign kind = m_tdata[KIND_LO+1:KIND_LO];
    assign len  = m_tdata[LEN_LO+7:LEN_LO];

    // a stalled result holds
    `ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // kind code is one of the three kinds
    `ASSERT_IMPL(a_kind_code, m_tvalid, kind != 2'd3)

    // a recognized kind needs a full tag in the body
    `ASSERT_IMPL(a_kind_len, m_tvalid && (kind != KIND_OTHER), len >= KIND_LEN)

    // pad bits stay zero
    `ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[OUT_WIDTH-1:PAD_LO] == '0)

    // the input side is never blocked with an empty output
    `ASSERT_IMPL(a_ready_free, !m_tvalid, s_tready)

endmodule

bind nmea_sentence_checksum_framer_core nmscf_checker u_nmscf_checker (.*);

`default_nettype wire
